[hdl/sfd_pkg.sv]
// shared types and codes for the frame deframer with xor checksum
// no dependencies; imported by every module of the block
package sfd_pkg;

  // frame phase of the parser
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  // end-of-frame status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADSTART = 2'd1,
    ST_BADSUM   = 2'd2,
    ST_TOOLONG  = 2'd3
  } status_t;

  // result kind
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

  localparam logic [7:0] CFG_RESET_VALUE = 8'hFF;

  // one received byte held in the input register
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_begin;
  } in_beat_t;

  // one result beat from parser to output register
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    status_t    status;
    logic       last;
  } result_t;

endpackage

[hdl/sfd_in_stage.sv]
// input register for received bytes
// depends on sfd_pkg
module sfd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sfd_pkg::in_beat_t in_beat,
  output logic             hold_valid,
  input  logic             hold_take,
  output sfd_pkg::in_beat_t hold_beat
);
  import sfd_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // refill when empty or whenever the held byte moves on in the same cycle
  assign in_ready   = !valid_r || hold_take;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_beat;
    end
  end

endmodule

[hdl/sfd_parser.sv]
// frame phase machine, checksum and index counters, configuration registers
// depends on sfd_pkg
module sfd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_wdata,
  input  logic                       step,
  input  sfd_pkg::in_beat_t          beat,
  output sfd_pkg::result_t           result
);
  import sfd_pkg::*;

  logic [7:0] sc_value_r;
  logic [7:0] max_length_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] held_length_r, held_length_nxt;
  logic [7:0] next_index_r, next_index_nxt;

  logic [7:0] b;
  logic       start_bad;
  logic       too_long;

  assign b         = beat.rx_byte;
  assign start_bad = (b != sc_value_r);
  assign too_long  = (b > max_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_value_r   <= CFG_RESET_VALUE;
      max_length_r <= CFG_RESET_VALUE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_CODE: sc_value_r   <= cfg_wdata;
        CFG_MAX_LENGTH: max_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (beat.frame_begin) begin
      phase_nxt = PH_START;
    end else begin
      unique case (phase_r)
        PH_START: phase_nxt = start_bad ? PH_IDLE : PH_LEN;
        PH_LEN: begin
          if (too_long)        phase_nxt = PH_IDLE;
          else if (b == 8'd0)  phase_nxt = PH_CHECK;
          else                 phase_nxt = PH_DATA;
        end
        PH_DATA:  phase_nxt = (bytes_left_r == 8'd1) ? PH_CHECK : PH_DATA;
        PH_CHECK: phase_nxt = PH_IDLE;
        default:  phase_nxt = PH_IDLE;
      endcase
    end
  end

  // counters and checksum
  always_comb begin
    bytes_left_nxt  = bytes_left_r;
    running_xor_nxt = running_xor_r;
    held_length_nxt = held_length_r;
    next_index_nxt  = next_index_r;
    if (beat.frame_begin) begin
      bytes_left_nxt  = 8'd0;
      running_xor_nxt = 8'd0;
      held_length_nxt = 8'd0;
      next_index_nxt  = 8'd0;
    end else begin
      case (phase_r)
        PH_LEN: begin
          held_length_nxt = b;
          if (!too_long) bytes_left_nxt = b;
        end
        PH_DATA: begin
          running_xor_nxt = running_xor_r ^ b;
          next_index_nxt  = next_index_r + 8'd1;
          bytes_left_nxt  = bytes_left_r - 8'd1;
        end
        default: ;
      endcase
    end
  end

  // result for this byte
  always_comb begin
    result = '0;
    if (!beat.frame_begin) begin
      unique case (phase_r)
        PH_START: begin
          if (start_bad) begin
            result.valid  = 1'b1;
            result.kind   = KIND_STATUS;
            result.status = ST_BADSTART;
            result.last   = 1'b1;
          end
        end
        PH_LEN: begin
          if (too_long) begin
            result.valid        = 1'b1;
            result.kind         = KIND_STATUS;
            result.frame_length = b;
            result.status       = ST_TOOLONG;
            result.last         = 1'b1;
          end
        end
        PH_DATA: begin
          result.valid      = 1'b1;
          result.kind       = KIND_DATA;
          result.data_byte  = b;
          result.byte_index = next_index_r;
        end
        PH_CHECK: begin
          result.valid        = 1'b1;
          result.kind         = KIND_STATUS;
          result.frame_length = held_length_r;
          result.status       = (b == running_xor_r) ? ST_OK : ST_BADSUM;
          result.last         = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_left_r  <= 8'd0;
      running_xor_r <= 8'd0;
      held_length_r <= 8'd0;
      next_index_r  <= 8'd0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_xor_r <= running_xor_nxt;
      held_length_r <= held_length_nxt;
      next_index_r  <= next_index_nxt;
    end
  end

endmodule

[hdl/sfd_out_reg.sv]
// result register feeding the output stream
// depends on sfd_pkg
module sfd_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sfd_pkg::result_t result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output sfd_pkg::result_t held
);
  import sfd_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign held      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && result.valid) begin
      res_r <= result;
    end
  end

endmodule

[hdl/spi_frame_deframer_xor_check_core.sv]
// top level of the length-prefixed frame deframer with xor checksum
// depends on sfd_pkg, sfd_in_stage, sfd_parser, sfd_out_reg
//
// Takes the received bytes of a framed serial transfer, one per input beat.
// A frame is: preamble (beat with in_tuser set), start code, length byte L,
// L data bytes and a checksum byte equal to the xor of the data bytes. Each
// data byte leaves as a data beat (out_tuser 0) with its index; the frame
// ends with one status beat (out_tuser 1, out_tlast 1) carrying the length
// and ok, bad start code, checksum mismatch or length over limit (lengths
// above max_length are refused at the length byte). A new preamble mid-frame
// drops the current frame silently; bytes outside a frame are ignored.
// Rate: one byte per clock, sustained. A byte is held in the input register;
// as it is taken on, the phase machine updates and the result register loads
// its result, which is then offered on the output stream. Both registers
// stall only while the result register holds an untaken beat.
// Configuration (index 0 start code, index 1 max length, both reset to 0xff)
// is to be written by the user only while the block is idle; not enforced.
module spi_frame_deframer_xor_check_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  // received byte stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,  // [7:0] rx_byte
  input  logic                          in_tuser,  // [0] frame_begin
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length,
  // [25:24] status, [31:26] zero
  output logic [31:0]                   out_tdata,
  output logic                          out_tuser, // [0] kind
  output logic                          out_tlast  // last
);
  import sfd_pkg::*;

  in_beat_t in_beat;
  in_beat_t hold_beat;
  logic     hold_valid;
  logic     out_free;
  logic     step;
  result_t  result;
  result_t  held;

  assign in_beat.rx_byte     = in_tdata;
  assign in_beat.frame_begin = in_tuser;

  // the held byte is consumed once the result register can take its result
  assign step = hold_valid && out_free;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .hold_valid (hold_valid),
    .hold_take  (step),
    .hold_beat  (hold_beat)
  );

  sfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .beat      (hold_beat),
    .result    (result)
  );

  sfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (result),
    .free      (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .held      (held)
  );

  assign out_tdata = {6'd0, held.status, held.frame_length, held.byte_index, held.data_byte};
  assign out_tuser = held.kind;
  assign out_tlast = held.last;

endmodule
